/* rtl/bpcp_pkg.sv */
`timescale 1ns / 1ps

package bpcp_pkg;

    // Width of the type 2 word count and of the counters that hold it.
    localparam int COUNT_BITS       = 27;
    localparam int TYPE1_COUNT_BITS = 11;
    localparam int REG_BITS         = 14;

    localparam logic [31:0] SYNC_WORD = 32'hAA99_5566;
    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam logic [31:0] KEEP_MASK_RESET    = 32'hFFFE_7FFF;
    localparam logic [31:0] SET_BITS_RESET     = 32'h0001_0000;
    localparam logic [31:0] CTRL_REPLACE_RESET = 32'h0000_0008;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEEP_MASK    = 2'd0;
    localparam logic [1:0] CFG_SET_BITS     = 2'd1;
    localparam logic [1:0] CFG_CTRL_REPLACE = 2'd2;

    // Configuration logic registers that the block cares about.
    localparam logic [REG_BITS-1:0] REG_CRC  = 14'd0;
    localparam logic [REG_BITS-1:0] REG_FDRI = 14'd2;
    localparam logic [REG_BITS-1:0] REG_CMD  = 14'd4;
    localparam logic [REG_BITS-1:0] REG_CTL  = 14'd5;
    localparam logic [REG_BITS-1:0] REG_MASK = 14'd6;
    localparam logic [REG_BITS-1:0] REG_COR  = 14'd9;

    localparam logic [31:0] CMD_RCRC = 32'd7;

    // Packet header codes.
    localparam logic [2:0] PKT_TYPE1 = 3'd1;
    localparam logic [2:0] PKT_TYPE2 = 3'd2;
    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_HEADER = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRCW   = 3'd4,
        PH_PASS   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_SEARCH    = 3'd0,
        ST_SYNC      = 3'd1,
        ST_HEADER    = 3'd2,
        ST_DATA      = 3'd3,
        ST_CRCW      = 3'd4,
        ST_PASS      = 3'd5,
        ST_TYPE2_ERR = 3'd6
    } status_t;

    typedef struct packed {
        logic [31:0] keep_mask;
        logic [31:0] set_bits;
        logic [31:0] ctrl_replace;
    } cfg_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic        last_word;
    } item_t;

    typedef struct packed {
        logic [31:0] word_out;
        status_t     status;
        logic [15:0] check_crc;
        logic        last_out;
    } result_t;

    // Reverses the bit order inside each byte; the byte order is kept.
    function automatic logic [31:0] swap_bits_in_bytes(input logic [31:0] w);
        logic [31:0] o;
        for (int b = 0; b < 4; b++) begin
            for (int i = 0; i < 8; i++) begin
                o[8*b+i] = w[8*b+7-i];
            end
        end
        return o;
    endfunction

    function automatic logic [15:0] reverse16(input logic [15:0] v);
        logic [15:0] o;
        for (int i = 0; i < 16; i++) begin
            o[i] = v[15-i];
        end
        return o;
    endfunction

    // One bit of the CRC-16 register, data taken least significant bit first.
    function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic d);
        logic [15:0] s;
        s = {crc[14:0], 1'b0};
        if (crc[15] ^ d) begin
            s = s ^ CRC_POLY;
        end
        return s;
    endfunction

    // A data word followed by the five register address bits; synthesis
    // flattens the unrolled shift into an XOR network.
    function automatic logic [15:0] crc_feed37(input logic [15:0] crc,
                                               input logic [36:0] bits);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 37; i++) begin
            c = crc_bit(c, bits[i]);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_feed16(input logic [15:0] crc,
                                               input logic [15:0] bits);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 16; i++) begin
            c = crc_bit(c, bits[i]);
        end
        return c;
    endfunction

endpackage

/* rtl/bpcp_cfg_regs.sv */
`timescale 1ns / 1ps

module bpcp_cfg_regs
    import bpcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Writes are always taken; an index beyond the register list is dropped.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.keep_mask    <= KEEP_MASK_RESET;
            cfg_reg.set_bits     <= SET_BITS_RESET;
            cfg_reg.ctrl_replace <= CTRL_REPLACE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KEEP_MASK:    cfg_reg.keep_mask    <= cfg_data;
                CFG_SET_BITS:     cfg_reg.set_bits     <= cfg_data;
                CFG_CTRL_REPLACE: cfg_reg.ctrl_replace <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/bpcp_parser.sv */
`timescale 1ns / 1ps

module bpcp_parser
    import bpcp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] header_count_reg, header_count_next;
    logic [COUNT_BITS-1:0] words_left_reg, words_left_next;
    logic [REG_BITS-1:0]   target_register_reg, target_register_next;
    logic [15:0]           original_crc_reg, original_crc_next;
    logic [15:0]           patched_crc_reg, patched_crc_next;

    logic [31:0]           r;
    logic [4:0]            reg5;
    logic [2:0]            pkt_type;
    logic [1:0]            pkt_op;
    logic [COUNT_BITS-1:0] hdr_count;
    logic                  hdr_type_ok;
    logic                  hdr_type2_err;
    logic                  hdr_op_ok;
    logic [COUNT_BITS-1:0] words_left_dec;
    logic [31:0]           patched_word;
    logic                  rcrc_hit;
    logic [15:0]           crc_word;
    logic [15:0]           orig_data_crc, patch_data_crc;
    logic [15:0]           orig_crcw_crc, patch_crcw_crc;

    logic [31:0]           word_step;
    status_t               status_step;
    logic [COUNT_BITS-1:0] header_count_step, words_left_step;
    logic [REG_BITS-1:0]   target_register_step;
    logic [15:0]           original_crc_step, patched_crc_step;

    // Decode of the incoming word.
    assign r           = swap_bits_in_bytes(item.data_word);
    assign reg5        = target_register_reg[4:0];
    assign pkt_type    = r[31:29];
    assign pkt_op      = r[28:27];
    assign hdr_count   = (pkt_type == PKT_TYPE1) ? COUNT_BITS'(r[TYPE1_COUNT_BITS-1:0])
                                                 : r[COUNT_BITS-1:0];
    assign hdr_type_ok   = (pkt_type == PKT_TYPE1) || (pkt_type == PKT_TYPE2);
    assign hdr_type2_err = (pkt_type == PKT_TYPE2) && (header_count_reg != '0);
    assign hdr_op_ok     = (pkt_op == OP_NOP) || (pkt_op == OP_WRITE);
    assign words_left_dec = words_left_reg - COUNT_BITS'(1);

    always_comb begin
        case (target_register_reg)
            REG_CRC:           patched_word = {16'h0000, reverse16(patched_crc_reg)};
            REG_COR:           patched_word = (r & cfg.keep_mask) | cfg.set_bits;
            REG_CTL, REG_MASK: patched_word = cfg.ctrl_replace;
            default:           patched_word = r;
        endcase
    end

    assign rcrc_hit       = (target_register_reg == REG_CMD) && (r == CMD_RCRC);
    assign crc_word       = reverse16(patched_crc_reg);
    assign orig_data_crc  = crc_feed37(original_crc_reg, {reg5, r});
    assign patch_data_crc = crc_feed37(patched_crc_reg, {reg5, patched_word});
    assign orig_crcw_crc  = crc_feed16(original_crc_reg, r[15:0]);
    assign patch_crcw_crc = crc_feed16(patched_crc_reg, crc_word);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SEARCH: begin
                if (r == SYNC_WORD) begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (!hdr_type_ok || hdr_type2_err || !hdr_op_ok) begin
                    phase_next = PH_PASS;
                end else if (hdr_count != '0) begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                if (words_left_dec == '0) begin
                    if ((target_register_reg == REG_FDRI) && (header_count_reg != '0)) begin
                        phase_next = PH_CRCW;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            PH_CRCW: phase_next = PH_HEADER;
            PH_PASS: phase_next = PH_PASS;
            default: phase_next = PH_SEARCH;
        endcase
        if (item.last_word) begin
            phase_next = PH_SEARCH;
        end
    end

    // Result word, status and the datapath state.
    always_comb begin
        word_step            = r;
        status_step          = ST_PASS;
        header_count_step    = header_count_reg;
        words_left_step      = words_left_reg;
        target_register_step = target_register_reg;
        original_crc_step    = original_crc_reg;
        patched_crc_step     = patched_crc_reg;
        case (phase_reg)
            PH_SEARCH: begin
                status_step = (r == SYNC_WORD) ? ST_SYNC : ST_SEARCH;
            end
            PH_HEADER: begin
                if (!hdr_type_ok) begin
                    status_step = ST_PASS;
                end else if (hdr_type2_err) begin
                    status_step = ST_TYPE2_ERR;
                end else begin
                    // Count and register are taken even when the op is bad.
                    header_count_step = hdr_count;
                    if (pkt_type == PKT_TYPE1) begin
                        target_register_step = r[26:13];
                    end
                    if (hdr_op_ok) begin
                        status_step     = ST_HEADER;
                        words_left_step = hdr_count;
                    end else begin
                        status_step = ST_PASS;
                    end
                end
            end
            PH_DATA: begin
                status_step     = ST_DATA;
                word_step       = patched_word;
                words_left_step = words_left_dec;
                if (rcrc_hit) begin
                    original_crc_step = '0;
                    patched_crc_step  = '0;
                end else begin
                    original_crc_step = orig_data_crc;
                    patched_crc_step  = patch_data_crc;
                end
            end
            PH_CRCW: begin
                status_step       = ST_CRCW;
                word_step         = {16'h0000, crc_word};
                original_crc_step = orig_crcw_crc;
                patched_crc_step  = patch_crcw_crc;
            end
            default: begin
                status_step = ST_PASS;
            end
        endcase

        // The end of a stream puts everything but the configuration registers back to reset.
        if (item.last_word) begin
            header_count_next    = '0;
            words_left_next      = '0;
            target_register_next = '0;
            original_crc_next    = CRC_INIT;
            patched_crc_next     = CRC_INIT;
        end else begin
            header_count_next    = header_count_step;
            words_left_next      = words_left_step;
            target_register_next = target_register_step;
            original_crc_next    = original_crc_step;
            patched_crc_next     = patched_crc_step;
        end
    end

    assign result.word_out  = swap_bits_in_bytes(word_step);
    assign result.status    = status_step;
    assign result.check_crc = original_crc_step;
    assign result.last_out  = item.last_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_SEARCH;
            header_count_reg    <= '0;
            words_left_reg      <= '0;
            target_register_reg <= '0;
            original_crc_reg    <= CRC_INIT;
            patched_crc_reg     <= CRC_INIT;
        end else if (step_en) begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            words_left_reg      <= words_left_next;
            target_register_reg <= target_register_next;
            original_crc_reg    <= original_crc_next;
            patched_crc_reg     <= patched_crc_next;
        end
    end

    // A data phase always has words still to come.
    a_data_has_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (words_left_reg != '0))
        else $error("data phase entered with no words left");

    // The CRC word only ever follows frame data.
    a_crcw_after_fdri: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CRCW) |-> (target_register_reg == REG_FDRI))
        else $error("CRC word phase outside a frame data packet");

    // The last word of a stream returns the parser to sync search with fresh CRCs.
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.last_word) |=>
            (phase_reg == PH_SEARCH) && (original_crc_reg == CRC_INIT)
            && (patched_crc_reg == CRC_INIT))
        else $error("state not cleared after the last word");

endmodule

/* rtl/bitstream_packet_crc_patcher_top.sv */
`timescale 1ns / 1ps

// Configuration bitstream CRC patcher. Each input transaction carries one
// 32-bit word of a configuration bitstream, four file bytes with the first
// in bits 31 to 24, and each produces exactly one output transaction with
// the word (possibly rewritten), a status code, the running CRC-16 over the
// original stream, and a copy of the last-word flag. The block hunts for the
// sync word, follows the packet headers, and rewrites writes to the CRC, COR,
// CTL and MASK registers as well as the CRC word after frame data, keeping a
// second CRC over the patched stream so that the rewritten bitstream still
// checks. A word flagged as last ends the stream and the block returns to
// sync search; the three configuration registers keep their values. The
// block takes one transaction per clock cycle without gaps while m_ready
// stays high: the complete parse and both 37-bit CRC updates sit in a
// single stage between the input register and the output register, and an
// accepted word waits in the input register until the output register can
// take its result, which then drives output valid. The input side is ready
// whenever its register is empty or moves on in the same cycle, which makes
// s_ready follow m_ready combinationally while both registers are full.
// Configuration writes are accepted in every cycle and must only be issued
// while no transaction is in flight.

module bitstream_packet_crc_patcher_top
    import bpcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // Input word channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic        s_last_word,

    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_word_out,
    output logic [2:0]  m_status,
    output logic [15:0] m_check_crc,
    output logic        m_last_out
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t step_result;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;

    bpcp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held word is processed, and the parser state moves on, in the
    // cycle in which the output register can take its result.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.data_word <= s_data_word;
            in_item_reg.last_word <= s_last_word;
        end
    end

    bpcp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_result;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_word_out  = out_res_reg.word_out;
    assign m_status    = out_res_reg.status;
    assign m_check_crc = out_res_reg.check_crc;
    assign m_last_out  = out_res_reg.last_out;

    // A full input register facing a stalled result must not take more.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are stalled");

    // Every processed word lands in the output register.
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed word did not reach the output register");

endmodule

/* tb/bitstream_packet_crc_patcher_top_tb.sv */
`timescale 1ns / 1ps

// Self-checking testbench for the bitstream CRC patcher. A driver process
// offers configuration words from a queue, a monitor process checks every
// result transaction against a prediction made when the word was accepted,
// and an initial block writes the three option registers between rounds and
// fills the word queue with bitstreams that a real configuration flow would
// produce, broken streams mixed in.

module bitstream_packet_crc_patcher_top_tb;
    import bpcp_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int ROUNDS       = 6;
    localparam int ROUND_WORDS  = 275;
    localparam int LONG_HOLD    = 240;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHOWN_FAULTS = 10;

    // Op codes that the block must refuse as bad headers.
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = CFG_KEEP_MASK;
    logic [31:0] cfg_data    = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word = '0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_word_out;
    logic [2:0]  m_status;
    logic [15:0] m_check_crc;
    logic        m_last_out;

    bitstream_packet_crc_patcher_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_word (s_data_word),
        .s_last_word (s_last_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word_out  (m_word_out),
        .m_status    (m_status),
        .m_check_crc (m_check_crc),
        .m_last_out  (m_last_out)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Words waiting to be offered, and the results that accepted words must
    // produce, oldest first.
    item_t       word_queue[$];
    result_t     expected_results[$];
    logic [31:0] stream_words[$];

    item_t   next_item;
    result_t want;

    // Traffic shaping, changed by the stimulus process or the hold timer with
    // nonblocking assignments so clocked processes see them at a clean edge.
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int hold_cycles_left = 0;
    bit hold_request     = 1'b0;
    bit hold_done        = 1'b0;

    int fault_count    = 0;
    int results_seen   = 0;
    int words_queued   = 0;
    int streams_queued = 0;
    int status_seen[8] = '{default: 0};

    // ------------------------------------------------------------------
    // Prediction. The state below mirrors what the block tracks for one
    // stream, plus its own copy of the option registers.
    // ------------------------------------------------------------------
    phase_t      stream_phase     = PH_SEARCH;
    logic [26:0] packet_count     = '0;
    logic [26:0] packet_remaining = '0;
    logic [13:0] packet_reg       = '0;
    logic [15:0] crc_as_received  = CRC_INIT;
    logic [15:0] crc_as_sent      = CRC_INIT;
    cfg_t        patch_cfg        = {KEEP_MASK_RESET, SET_BITS_RESET, CTRL_REPLACE_RESET};

    // Bit order is reversed within each byte; applying it twice is the
    // identity, so it serves for both file-to-word and word-to-file.
    function automatic logic [31:0] flip_byte_bits(input logic [31:0] w);
        logic [31:0] o;
        for (int i = 0; i < 32; i++) begin
            o[i] = w[(i & ~7) + 7 - (i & 7)];
        end
        return o;
    endfunction

    function automatic logic [15:0] mirror16(input logic [15:0] v);
        logic [15:0] o;
        for (int i = 0; i < 16; i++) begin
            o[i] = v[15 - i];
        end
        return o;
    endfunction

    // Shifts the low n bits of data into the CRC, least significant first.
    function automatic logic [15:0] crc16_shift(input logic [15:0] crc,
                                                input logic [31:0] bits,
                                                input int n);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < n; i++) begin
            fb = c[15] ^ bits[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Works out the result of one accepted word and advances the stream
    // state exactly as the block should.
    function automatic result_t predict_patch(input logic [31:0] raw, input logic last);
        logic [31:0] cw;
        logic [4:0]  addr5;
        logic [2:0]  ptype;
        logic [1:0]  pop;
        logic [15:0] mirrored;
        status_t     st;
        result_t     res;
        cw    = flip_byte_bits(raw);
        addr5 = packet_reg[4:0];
        st    = ST_SEARCH;
        case (stream_phase)
            PH_SEARCH: begin
                if (cw == SYNC_WORD) begin
                    stream_phase = PH_HEADER;
                    st           = ST_SYNC;
                end
            end
            PH_HEADER: begin
                ptype = cw[31:29];
                pop   = cw[28:27];
                st    = ST_HEADER;
                if (ptype == PKT_TYPE2 && packet_count != '0) begin
                    // A type 2 header is only legal while the last packet count is zero.
                    stream_phase = PH_PASS;
                    st           = ST_TYPE2_ERR;
                end else if (ptype != PKT_TYPE1 && ptype != PKT_TYPE2) begin
                    stream_phase = PH_PASS;
                    st           = ST_PASS;
                end else begin
                    if (ptype == PKT_TYPE1) begin
                        packet_count = 27'(cw[TYPE1_COUNT_BITS-1:0]);
                        packet_reg   = cw[26:13];
                    end else begin
                        packet_count = 27'(cw[COUNT_BITS-1:0]);
                    end
                    if (pop != OP_NOP && pop != OP_WRITE) begin
                        stream_phase = PH_PASS;
                        st           = ST_PASS;
                    end else begin
                        packet_remaining = packet_count;
                        if (packet_count != '0) begin
                            stream_phase = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA: begin
                st              = ST_DATA;
                crc_as_received = crc16_shift(crc16_shift(crc_as_received, cw, 32),
                                              {27'b0, addr5}, 5);
                if (packet_reg == REG_CRC) begin
                    cw = {16'h0, mirror16(crc_as_sent)};
                end
                if (packet_reg == REG_COR) begin
                    cw = (cw & patch_cfg.keep_mask) | patch_cfg.set_bits;
                end
                if (packet_reg == REG_CTL || packet_reg == REG_MASK) begin
                    cw = patch_cfg.ctrl_replace;
                end
                if (packet_reg == REG_CMD && cw == CMD_RCRC) begin
                    crc_as_received = '0;
                    crc_as_sent     = '0;
                end else begin
                    crc_as_sent = crc16_shift(crc16_shift(crc_as_sent, cw, 32),
                                              {27'b0, addr5}, 5);
                end
                packet_remaining = packet_remaining - 27'd1;
                if (packet_remaining == '0) begin
                    stream_phase = (packet_reg == REG_FDRI && packet_count != '0) ?
                                   PH_CRCW : PH_HEADER;
                end
            end
            PH_CRCW: begin
                st              = ST_CRCW;
                mirrored        = mirror16(crc_as_sent);
                crc_as_received = crc16_shift(crc_as_received, cw, 16);
                crc_as_sent     = crc16_shift(crc_as_sent, {16'h0, mirrored}, 16);
                cw              = {16'h0, mirrored};
                stream_phase    = PH_HEADER;
            end
            default: begin
                st = ST_PASS;
            end
        endcase
        res.word_out  = flip_byte_bits(cw);
        res.status    = st;
        res.check_crc = crc_as_received;
        res.last_out  = last;
        if (last) begin
            stream_phase     = PH_SEARCH;
            packet_count     = '0;
            packet_remaining = '0;
            packet_reg       = '0;
            crc_as_received  = CRC_INIT;
            crc_as_sent      = CRC_INIT;
        end
        return res;
    endfunction

    // The option registers in the prediction follow the write channel.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KEEP_MASK:    patch_cfg.keep_mask    = cfg_data;
                CFG_SET_BITS:     patch_cfg.set_bits     = cfg_data;
                CFG_CTRL_REPLACE: patch_cfg.ctrl_replace = cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Driver. A word that has been accepted is predicted from the values
    // still on the port at this edge; a new word is only offered once the
    // previous one has gone, and a gap is only taken with valid low.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_patch(s_data_word, s_last_word));
            end
            if (!s_valid || s_ready) begin
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = word_queue.pop_front();
                    s_valid     <= 1'b1;
                    s_data_word <= next_item.data_word;
                    s_last_word <= next_item.last_word;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // The long hold-off on the result side is timed here, in cycles, so that
    // the sender keeps offering words while the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles_left <= 0;
        end else if (hold_cycles_left != 0) begin
            hold_cycles_left <= hold_cycles_left - 1;
        end else if (hold_request && !hold_done) begin
            hold_cycles_left <= LONG_HOLD;
            hold_done        <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_cycles_left != 0) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each result transaction is compared field by field with the
    // oldest prediction; the first few faults are shown in full.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOWN_FAULTS) begin
                    $display("%0t: result with nothing pending: word %h status %0d crc %h last %b",
                             $realtime, m_word_out, m_status, m_check_crc, m_last_out);
                end
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                status_seen[m_status]++;
                if (m_word_out !== want.word_out || m_status !== want.status ||
                    m_check_crc !== want.check_crc || m_last_out !== want.last_out) begin
                    fault_count++;
                    if (fault_count <= SHOWN_FAULTS) begin
                        $display("%0t: result %0d wrong (expected / actual):", $realtime,
                                 results_seen);
                        $display("    word %h / %h  status %0d / %0d  crc %h / %h  last %b / %b",
                                 want.word_out, m_word_out, want.status, m_status,
                                 want.check_crc, m_check_crc, want.last_out, m_last_out);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Streams are built as configuration words and only
    // turned into file byte order when they are queued.
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    // A quarter of the words are near misses of the sync word, so that the search is tested.
    function automatic logic [31:0] noise_word();
        if ($urandom_range(3) == 0) begin
            return SYNC_WORD ^ (32'd1 << $urandom_range(31));
        end
        return rand_word();
    endfunction

    // The two spare bits between register and count are filled at random.
    function automatic logic [31:0] type1_header(input logic [1:0] op,
                                                 input logic [13:0] target,
                                                 input logic [10:0] count);
        return {PKT_TYPE1, op, target, 2'($urandom_range(3)), count};
    endfunction

    function automatic logic [31:0] type2_header(input logic [1:0] op,
                                                 input logic [COUNT_BITS-1:0] count);
        return {PKT_TYPE2, op, count};
    endfunction

    // Moves the stream under construction into the word queue, with the
    // final word marked as the end of the stream.
    task automatic flush_stream();
        item_t it;
        foreach (stream_words[i]) begin
            it.data_word = flip_byte_bits(stream_words[i]);
            it.last_word = (i == stream_words.size() - 1);
            word_queue.push_back(it);
        end
        words_queued += stream_words.size();
        streams_queued++;
        stream_words.delete();
    endtask

    // One stream: a little noise, the sync word, then a handful of packets
    // of the kinds a configuration flow writes. Now and then a packet is
    // broken, and now and then the stream is cut short anywhere.
    task automatic build_random_stream();
        int          n_packets;
        int          kind;
        int          count;
        int          keep;
        logic [13:0] target;
        bit          open;
        repeat ($urandom_range(2)) stream_words.push_back(noise_word());
        stream_words.push_back(SYNC_WORD);
        n_packets = $urandom_range(1, 6);
        open      = 1'b1;
        for (int p = 0; p < n_packets && open; p++) begin
            kind = $urandom_range(99);
            if (kind < 14) begin
                stream_words.push_back(type1_header(OP_WRITE, REG_CMD, 11'd1));
                stream_words.push_back(($urandom_range(4) != 0) ? CMD_RCRC : rand_word());
            end else if (kind < 28) begin
                count = $urandom_range(1, 2);
                stream_words.push_back(type1_header(OP_WRITE, REG_COR, 11'(count)));
                repeat (count) stream_words.push_back(rand_word());
            end else if (kind < 40) begin
                count  = $urandom_range(1, 2);
                target = ($urandom_range(1) != 0) ? REG_CTL : REG_MASK;
                stream_words.push_back(type1_header(OP_WRITE, target, 11'(count)));
                repeat (count) stream_words.push_back(rand_word());
            end else if (kind < 52) begin
                stream_words.push_back(type1_header(OP_WRITE, REG_CRC, 11'd1));
                stream_words.push_back(rand_word());
            end else if (kind < 72) begin
                // Frame data, followed by the CRC word that the block rewrites.
                if ($urandom_range(2) == 0) begin
                    count = $urandom_range(1, 4);
                    stream_words.push_back(type1_header(OP_WRITE, REG_FDRI, 11'(count)));
                end else begin
                    count = ($urandom_range(19) == 0) ? $urandom_range(7, 40) :
                                                        $urandom_range(1, 6);
                    stream_words.push_back(type1_header(OP_WRITE, REG_FDRI, 11'd0));
                    stream_words.push_back(type2_header(OP_WRITE, COUNT_BITS'(count)));
                end
                repeat (count) stream_words.push_back(rand_word());
                stream_words.push_back(rand_word());
            end else if (kind < 80) begin
                stream_words.push_back(type1_header(OP_NOP, 14'($urandom), 11'd0));
            end else if (kind < 92) begin
                target = ($urandom_range(1) != 0) ? 14'($urandom_range(31)) : 14'($urandom);
                if ($urandom_range(39) == 0) begin
                    // Largest type 1 count; the stream ends inside the packet.
                    stream_words.push_back(type1_header(OP_WRITE, target, 11'h7FF));
                    repeat (2) stream_words.push_back(rand_word());
                    open = 1'b0;
                end else begin
                    count = $urandom_range(3);
                    stream_words.push_back(type1_header(OP_WRITE, target, 11'(count)));
                    repeat (count) stream_words.push_back(rand_word());
                end
            end else begin
                case ($urandom_range(2))
                    // Types 3 to 7 and 0 are all illegal.
                    0: stream_words.push_back({3'($urandom_range(3, 8)), 29'($urandom)});
                    1: stream_words.push_back(type1_header(
                           ($urandom_range(1) != 0) ? OP_READ : OP_RESERVED,
                           14'($urandom), 11'($urandom)));
                    default: begin
                        stream_words.push_back(type1_header(OP_WRITE, REG_COR, 11'd1));
                        stream_words.push_back(rand_word());
                        stream_words.push_back(type2_header(OP_WRITE,
                                                            COUNT_BITS'($urandom_range(1, 9))));
                    end
                endcase
                repeat ($urandom_range(1, 3)) stream_words.push_back(rand_word());
                open = 1'b0;
            end
        end
        if ($urandom_range(11) == 0) begin
            keep = $urandom_range(1, stream_words.size());
            while (stream_words.size() > keep) begin
                stream_words.delete(stream_words.size() - 1);
            end
        end
        flush_stream();
    endtask

    // The block is only reconfigured with nothing in flight.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] keep_mask,
                                  input logic [31:0] set_bits,
                                  input logic [31:0] ctrl_replace);
        write_register(CFG_KEEP_MASK, keep_mask);
        write_register(CFG_SET_BITS, set_bits);
        write_register(CFG_CTRL_REPLACE, ctrl_replace);
    endtask

    // Waits until every queued word has been accepted and every result has
    // come back, then lets the two-stage pipeline settle.
    task automatic wait_until_quiet();
        do @(posedge aclk);
        while (word_queue.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence: six rounds, new option settings before all but the first,
    // three traffic patterns. The first round starts with hand-written streams.
    // ------------------------------------------------------------------
    initial begin
        int round_start;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        for (int round = 0; round < ROUNDS; round++) begin
            case (round)
                1: apply_settings($urandom, $urandom, $urandom);
                2: apply_settings('0, '1, '0);
                3: apply_settings('1, '0, '1);
                4: apply_settings($urandom, $urandom, $urandom);
                5: apply_settings(KEEP_MASK_RESET, SET_BITS_RESET, CTRL_REPLACE_RESET);
                default: ;
            endcase
            @(posedge aclk);
            if (round < 2) begin
                send_idle_pct <= 36;
                recv_idle_pct <= 79;
            end else if (round < 4) begin
                send_idle_pct <= 79;
                recv_idle_pct <= 36;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            round_start = words_queued;
            if (round == 0) begin
                // Every special register write, a command that clears both
                // CRCs, zero-count packets, frame data by a type 2 header and
                // its CRC word, and finally a header with a bad op.
                stream_words.push_back(SYNC_WORD);
                stream_words.push_back(type1_header(OP_WRITE, REG_CMD, 11'd1));
                stream_words.push_back(CMD_RCRC);
                stream_words.push_back(type1_header(OP_WRITE, REG_CTL, 11'd1));
                stream_words.push_back($urandom);
                stream_words.push_back(type1_header(OP_WRITE, REG_MASK, 11'd1));
                stream_words.push_back('1);
                stream_words.push_back(type1_header(OP_WRITE, REG_COR, 11'd1));
                stream_words.push_back('0);
                stream_words.push_back(type1_header(OP_WRITE, REG_FDRI, 11'd0));
                stream_words.push_back(type2_header(OP_WRITE, COUNT_BITS'(2)));
                stream_words.push_back($urandom);
                stream_words.push_back($urandom);
                stream_words.push_back($urandom);
                stream_words.push_back(type1_header(OP_WRITE, REG_CRC, 11'd1));
                stream_words.push_back($urandom);
                stream_words.push_back(type1_header(OP_NOP, REG_CRC, 11'd0));
                stream_words.push_back(type1_header(OP_READ, REG_COR, 11'd1));
                flush_stream();
                // A type 2 header after a nonzero count, then passthrough.
                stream_words.push_back(SYNC_WORD);
                stream_words.push_back(type1_header(OP_WRITE, REG_COR, 11'd1));
                stream_words.push_back($urandom);
                stream_words.push_back(type2_header(OP_WRITE, COUNT_BITS'(1)));
                stream_words.push_back($urandom);
                flush_stream();
                // An illegal packet type.
                stream_words.push_back(SYNC_WORD);
                stream_words.push_back({3'd7, 29'($urandom)});
                flush_stream();
                // The largest type 2 count; the stream stops inside the packet.
                stream_words.push_back(SYNC_WORD);
                stream_words.push_back(type1_header(OP_WRITE, REG_FDRI, 11'd0));
                stream_words.push_back(type2_header(OP_WRITE, '1));
                stream_words.push_back($urandom);
                flush_stream();
            end
            while (words_queued - round_start < ROUND_WORDS) begin
                build_random_stream();
            end
            // In the last round the result side is held off for a long
            // stretch while words keep coming, so that the block backs up.
            if (round == ROUNDS - 1) begin
                hold_request <= 1'b1;
            end
            wait_until_quiet();
        end

        if (expected_results.size() != 0) begin
            fault_count++;
            $display("%0d results never arrived", expected_results.size());
        end
        $display("Covered %0d words in %0d streams under %0d option settings, %0d results checked, %0d faults.",
                 words_queued, streams_queued, ROUNDS, results_seen, fault_count);
        $display("Statuses seen: search %0d, sync %0d, header %0d, data %0d, crc word %0d, passthrough %0d, type 2 error %0d.",
                 status_seen[ST_SEARCH], status_seen[ST_SYNC], status_seen[ST_HEADER],
                 status_seen[ST_DATA], status_seen[ST_CRCW], status_seen[ST_PASS],
                 status_seen[ST_TYPE2_ERR]);
        if (fault_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // A correct run takes a few tens of microseconds; this is far beyond it.
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
